// ===== src/sfr_pkg.sv =====
// Shared types and constants of the stream find-and-replace block.
// Used by sfr_front, sfr_queue, sfr_back and stream_find_and_replace.
// No dependencies.
package sfr_pkg;

  // Ceilings of the pattern and replacement sizes (bytes)
  localparam int unsigned MAX_PATTERN_C     = 8;
  localparam int unsigned MAX_REPLACEMENT_C = 8;

  // Configuration port
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned LEN_W      = 4;

  // Job fields
  localparam int unsigned WIN_IDX_W  = $clog2(MAX_PATTERN_C);
  localparam int unsigned REPL_IDX_W = $clog2(MAX_REPLACEMENT_C);
  localparam int unsigned BEAT_CNT_W = $clog2(MAX_PATTERN_C + MAX_REPLACEMENT_C + 1);

  // Job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH     = 2'd0,
    CFG_PATTERN_BYTES      = 2'd1,
    CFG_REPLACEMENT_LENGTH = 2'd2,
    CFG_REPLACEMENT_BYTES  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LEN_W-1:0]      pattern_length;
    logic [CFG_DATA_W-1:0] pattern_bytes;
    logic [LEN_W-1:0]      replacement_length;
    logic [CFG_DATA_W-1:0] replacement_bytes;
  } cfg_t;

  // One classified item: window bytes to release, then optional replacement
  typedef struct packed {
    logic [MAX_PATTERN_C-1:0][7:0] win;
    logic [BEAT_CNT_W-1:0]         emit_cnt;
    logic                          repl;
    logic                          last;
  } job_t;

endpackage

// ===== src/sfr_front.sv =====
// Front end: accepts input beats, matches the held window against the pattern,
// keeps the partial-match bytes and hands a job to the queue.
// Depends on sfr_pkg.
module sfr_front #(
  parameter int unsigned MAX_PATTERN = sfr_pkg::MAX_PATTERN_C
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfr_pkg::cfg_t cfg_i,
  input  logic          clear_i,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  output logic          push_o,
  output sfr_pkg::job_t job_o
);

  localparam int unsigned HC_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned CW   = HC_W + 1;

  logic [7:0]      held_q [MAX_PATTERN];
  logic [7:0]      held_next [MAX_PATTERN];
  logic [HC_W-1:0] hc_q, hc_d;
  logic [7:0]      win [MAX_PATTERN];
  logic [HC_W-1:0] m;
  logic [HC_W-1:0] plen_eff;
  logic [MAX_PATTERN:0] ok;
  logic [HC_W-1:0] s_sel;
  logic [CW-1:0]   rem;
  logic            matched;
  logic            accept;

  assign accept = in_valid_i && in_ready_i;
  assign push_o = accept;

  // Effective pattern length: zero reads as one, clamp at the maximum
  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      plen_eff = HC_W'(1);
    end else if (cfg_i.pattern_length > sfr_pkg::LEN_W'(MAX_PATTERN)) begin
      plen_eff = HC_W'(MAX_PATTERN);
    end else begin
      plen_eff = HC_W'(cfg_i.pattern_length);
    end
  end

  // Window: held bytes followed by the new byte
  assign m = hc_q + HC_W'(1);
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (HC_W'(i) < hc_q) begin
        win[i] = held_q[i];
      end else if (HC_W'(i) == hc_q) begin
        win[i] = in_byte_i;
      end else begin
        win[i] = 8'h00;
      end
    end
  end

  // Per start offset: is the remainder a prefix of the pattern (or all of it)
  always_comb begin
    logic all_eq;
    for (int s = 0; s <= MAX_PATTERN; s++) begin
      all_eq = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (s + i < MAX_PATTERN) begin
          if ((CW'(s + i) < {1'b0, m}) &&
              (win[s + i] != cfg_i.pattern_bytes[8*i +: 8])) begin
            all_eq = 1'b0;
          end
        end
      end
      ok[s] = (CW'(s) <= {1'b0, m}) &&
              (({1'b0, m} - CW'(s)) <= {1'b0, plen_eff}) && all_eq;
    end
  end

  // Smallest offset wins
  always_comb begin
    s_sel = HC_W'(MAX_PATTERN);
    for (int s = MAX_PATTERN; s >= 0; s--) begin
      if (ok[s]) begin
        s_sel = HC_W'(s);
      end
    end
  end

  assign rem     = {1'b0, m} - {1'b0, s_sel};
  assign matched = (rem == {1'b0, plen_eff});

  // Remainder shifted down to the front of the hold buffer
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      held_next[i] = 8'h00;
      for (int s = 0; s < MAX_PATTERN; s++) begin
        if ((s + i < MAX_PATTERN) && (s_sel == HC_W'(s))) begin
          held_next[i] = win[s + i];
        end
      end
    end
  end

  // Job for the back end
  always_comb begin
    job_o = '0;
    for (int j = 0; j < sfr_pkg::MAX_PATTERN_C; j++) begin
      if (j < MAX_PATTERN) begin
        job_o.win[j] = win[j];
      end
    end
    if (matched) begin
      job_o.emit_cnt = '0;
    end else if (in_last_i) begin
      job_o.emit_cnt = sfr_pkg::BEAT_CNT_W'(m);
    end else begin
      job_o.emit_cnt = sfr_pkg::BEAT_CNT_W'(s_sel);
    end
    job_o.repl = matched;
    job_o.last = in_last_i;
  end

  // Hold count; a pattern write drops what is held
  always_comb begin
    hc_d = hc_q;
    if (clear_i) begin
      hc_d = '0;
    end else if (accept) begin
      hc_d = (matched || in_last_i) ? '0 : rem[HC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q <= '0;
    end else begin
      hc_q <= hc_d;
    end
  end

  // Hold buffer payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_next;
    end
  end

endmodule

// ===== src/sfr_queue.sv =====
// Short job queue between the front and the back end.
// Depends on sfr_pkg.
module sfr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfr_pkg::job_t job_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          valid_o,
  output sfr_pkg::job_t job_o
);

  localparam int unsigned DEPTH = sfr_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sfr_pkg::job_t    entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== src/sfr_back.sv =====
// Back end: walks the job at the queue head and sends one result beat per
// cycle into the output register while the receiver does not stall. Depends on sfr_pkg.
module sfr_back #(
  parameter int unsigned MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_C
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfr_pkg::cfg_t cfg_i,
  input  logic          head_valid_i,
  input  sfr_pkg::job_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_has_byte_o,
  output logic          out_last_o,
  output logic          stream_end_o
);

  localparam int unsigned CNT_W = sfr_pkg::BEAT_CNT_W;

  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] rlen_eff, total, last_k, rep_idx;
  logic             can_load, skip, load, final_beat, has_byte;
  logic [7:0]       beat_byte;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_has_byte_q, out_last_q, stream_end_q;

  // Effective replacement length
  always_comb begin
    if (cfg_i.replacement_length > sfr_pkg::LEN_W'(MAX_REPLACEMENT)) begin
      rlen_eff = CNT_W'(MAX_REPLACEMENT);
    end else begin
      rlen_eff = CNT_W'(cfg_i.replacement_length);
    end
  end

  // Beat selection for the current position in the job
  always_comb begin
    total      = head_i.emit_cnt + (head_i.repl ? rlen_eff : '0);
    last_k     = (total == '0) ? '0 : total - CNT_W'(1);
    has_byte   = (total != '0);
    rep_idx    = k_q - head_i.emit_cnt;
    if (!has_byte) begin
      beat_byte = 8'h00;
    end else if (k_q < head_i.emit_cnt) begin
      beat_byte = head_i.win[k_q[sfr_pkg::WIN_IDX_W-1:0]];
    end else begin
      beat_byte = cfg_i.replacement_bytes[8*rep_idx[sfr_pkg::REPL_IDX_W-1:0] +: 8];
    end
    can_load   = !out_valid_q || out_ready_i;
    skip       = head_valid_i && !has_byte && !head_i.last;
    load       = head_valid_i && can_load && !skip;
    final_beat = (k_q == last_k);
    pop_o      = skip || (load && final_beat);
    if (pop_o) begin
      k_d = '0;
    end else if (load) begin
      k_d = k_q + CNT_W'(1);
    end else begin
      k_d = k_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q <= k_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output beat payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q     <= beat_byte;
      out_has_byte_q <= has_byte;
      out_last_q     <= final_beat;
      stream_end_q   <= final_beat && head_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign out_has_byte_o = out_has_byte_q;
  assign out_last_o     = out_last_q;
  assign stream_end_o   = stream_end_q;

endmodule

// ===== src/stream_find_and_replace.sv =====
// Top level of the stream find-and-replace block: configuration registers,
// front end, job queue and back end. Depends on sfr_pkg, sfr_front,
// sfr_queue and sfr_back.
//
// Usage:
//   Input beats (in_byte_i, in_last_i) arrive on a valid/ready channel; edited
//   bytes leave on a valid/ready channel, one byte per beat. out_last_o marks
//   the last beat caused by one input beat, stream_end_o the last beat of the
//   stream; a beat with out_has_byte_o low is a bare end mark (byte zero).
//   Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i while
//   the block is idle; writing the pattern length or bytes drops held bytes.
// Flow:
//   The front takes one input beat per cycle while the two-entry job queue has
//   room. With the back idle, the first result of an item passes through the
//   job queue and then the output register before it is presented.
//   The back sends one result beat per cycle while the receiver takes beats;
//   an item yields n results (n up to 8), and the output beat rate sets the
//   sustained item rate.
// Reset:
//   Pattern length 1, pattern, replacement and replacement length zero,
//   nothing held, queue and output register empty.
// Stall:
//   A stalled receiver holds the output register, the back stops, the queue
//   fills and in_ready_o drops; nothing is lost.
module stream_find_and_replace #(
  parameter int unsigned MAX_PATTERN     = sfr_pkg::MAX_PATTERN_C,
  parameter int unsigned MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_C
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     in_byte_i,
  input  logic                           in_last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_byte_o,
  output logic                           out_has_byte_o,
  output logic                           out_last_o,
  output logic                           stream_end_o
);

  sfr_pkg::cfg_t cfg_q;
  logic          pat_clear;
  logic          q_push, q_ready, q_pop, q_valid;
  sfr_pkg::job_t q_in, q_head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_length     <= sfr_pkg::LEN_W'(1);
      cfg_q.pattern_bytes      <= '0;
      cfg_q.replacement_length <= '0;
      cfg_q.replacement_bytes  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sfr_pkg::CFG_PATTERN_LENGTH: begin
          cfg_q.pattern_length <= cfg_data_i[sfr_pkg::LEN_W-1:0];
        end
        sfr_pkg::CFG_PATTERN_BYTES: begin
          cfg_q.pattern_bytes <= cfg_data_i;
        end
        sfr_pkg::CFG_REPLACEMENT_LENGTH: begin
          cfg_q.replacement_length <= cfg_data_i[sfr_pkg::LEN_W-1:0];
        end
        sfr_pkg::CFG_REPLACEMENT_BYTES: begin
          cfg_q.replacement_bytes <= cfg_data_i;
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  assign pat_clear = cfg_we_i &&
                     ((cfg_index_i == sfr_pkg::CFG_PATTERN_LENGTH) ||
                      (cfg_index_i == sfr_pkg::CFG_PATTERN_BYTES));

  assign in_ready_o = q_ready;

  sfr_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .clear_i    (pat_clear),
    .in_valid_i (in_valid_i),
    .in_ready_i (q_ready),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .push_o     (q_push),
    .job_o      (q_in)
  );

  sfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_in),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_head)
  );

  sfr_back #(
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_valid_i   (q_valid),
    .head_i         (q_head),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .out_has_byte_o (out_has_byte_o),
    .out_last_o     (out_last_o),
    .stream_end_o   (stream_end_o)
  );

  // A stream end beat always closes the run of its input beat
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_end_o |-> out_last_o)
    else $error("stream end without last flag");

  // A bare mark carries a zero byte and only ever ends a stream
  a_bare_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_has_byte_o |-> (out_byte_o == 8'h00) && stream_end_o)
    else $error("bare mark malformed");

  // A new output beat is only loaded from a queued job
  a_beat_from_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(q_valid))
    else $error("output beat without queued job");

  // The back never pops an empty queue
  a_pop_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop of empty job queue");

endmodule
